>>> sv/dpm_pkg.sv
`default_nettype none
package dpm_pkg;
	localparam int PAGE_BYTES = 32;
	localparam int VIRT_PAGES = 16;
	localparam int FRAMES = 32;
	localparam int PROCS = 8;
	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int VP_W = $clog2(VIRT_PAGES);
	localparam int FR_W = $clog2(FRAMES);
	localparam int PID_W = $clog2(PROCS);
	localparam int PT_AW = PID_W + VP_W;
	localparam int PM_AW = FR_W + OFF_W;
	localparam int NP_W = $clog2(VIRT_PAGES + 1);
	localparam int BUD_W = $clog2(FRAMES + 1);

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_CREATE = 2'd0;
	localparam opcode_t OP_READ = 2'd1;
	localparam opcode_t OP_WRITE = 2'd2;
	localparam opcode_t OP_EXIT = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_TOO_LARGE = 3'd1;
	localparam status_t ST_NO_SLOT = 3'd2;
	localparam status_t ST_NO_PAGES = 3'd3;
	localparam status_t ST_BOUNDS = 3'd4;
	localparam status_t ST_NO_FRAME = 3'd5;
	localparam status_t ST_NOT_RUNNING = 3'd6;

	// page table entry: present + frame
	typedef struct packed {
		logic present;
		logic [FR_W-1:0] frame;
	} pte_t;

	typedef struct packed {
		logic we;
		logic [PT_AW-1:0] addr;
		pte_t wd;
	} pt_req_t;

	typedef struct packed {
		logic we;
		logic [PM_AW-1:0] addr;
		logic [7:0] wd;
	} pm_req_t;
endpackage
`default_nettype wire

>>> sv/dpm_ptab.sv
`default_nettype none
module dpm_ptab (
	input wire logic clk,
	input wire dpm_pkg::pt_req_t req,
	output dpm_pkg::pte_t rd
);
	import dpm_pkg::*;
	pte_t mem_q [PROCS*VIRT_PAGES];
	always_ff @(posedge clk) begin
		if (req.we) mem_q[req.addr] <= req.wd;
		rd <= mem_q[req.addr];
	end
endmodule
`default_nettype wire

>>> sv/dpm_pmem.sv
`default_nettype none
module dpm_pmem (
	input wire logic clk,
	input wire dpm_pkg::pm_req_t req,
	output logic [7:0] rd
);
	import dpm_pkg::*;
	logic [7:0] mem_q [FRAMES*PAGE_BYTES];
	always_ff @(posedge clk) begin
		if (req.we) mem_q[req.addr] <= req.wd;
		rd <= mem_q[req.addr];
	end
endmodule
`default_nettype wire

>>> sv/demand_paging_mmu.sv
`default_nettype none
// Demand-paging memory manager for PROCS process slots.
// Input channel (in_valid/in_ready) carries one operation per word: create,
// read byte, write byte or exit. Output channel (out_valid/out_ready) returns
// one word per operation: status, new_pid and rdata.
// One operation is in flight at a time. Steps from accept to out_valid:
//   create               result state only
//   read/write           table read, frame map, memory access
//   no free frame        table read, frame map
//   exit                 walk over all VIRT_PAGES page table entries
//   other error results  result state only
// With out_ready high the next word can be accepted in the same cycle out_valid rises.
// Exit walks the slot's page table through the single table port, reading
// and clearing one entry per cycle.
// After reset a clearing pass writes every page table entry not present,
// while in_ready stays low.
// A result waits in the output register while out_ready is low; the next
// word is accepted in the same cycle the result is taken.
// Frame use, slot state and the page budget live in flip-flops; page table
// and physical memory are single port synchronous RAMs.
module demand_paging_mmu (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] opcode,
	input wire logic [2:0] proc_id,
	input wire logic [8:0] vaddr,
	input wire logic [9:0] req_size,
	input wire logic [7:0] wdata,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [2:0] new_pid,
	output logic [7:0] rdata
);
	import dpm_pkg::*;

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MAP = 3'd3;
	localparam logic [2:0] S_MEM = 3'd4;
	localparam logic [2:0] S_EXIT = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [PT_AW:0] clr_q;
	logic [PROCS-1:0] run_q;
	logic [NP_W-1:0] pages_q [PROCS];
	logic [FRAMES-1:0] fused_q;
	logic [BUD_W-1:0] budget_q;
	opcode_t op_q;
	logic [PID_W-1:0] pid_q;
	logic [OFF_W-1:0] off_q;
	logic [VP_W-1:0] vp_q;
	logic [7:0] wd_q;
	logic [FR_W-1:0] frame_q;
	logic [VP_W:0] walk_q;
	logic rd_pend_q;
	pt_req_t pt_req;
	pte_t pt_rd;
	pm_req_t pm_req;
	logic [7:0] pm_rd;

	dpm_ptab u_ptab (.clk(clk), .req(pt_req), .rd(pt_rd));
	dpm_pmem u_pmem (.clk(clk), .req(pm_req), .rd(pm_rd));

	logic accept, take;
	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign accept = in_valid && in_ready;
	assign take = out_valid && out_ready;

	// create decode
	logic [NP_W-1:0] need;
	logic too_large;
	logic free_found;
	logic [PID_W-1:0] free_pid;
	always_comb begin
		logic [9:0] sum;
		sum = req_size + 10'(PAGE_BYTES - 1);
		too_large = {1'b0, req_size} > 11'(VIRT_PAGES * PAGE_BYTES);
		need = NP_W'(sum >> OFF_W);
		free_found = 1'b0;
		free_pid = '0;
		for (int i = PROCS - 1; i >= 0; i--) begin
			if (!run_q[i]) begin
				free_found = 1'b1;
				free_pid = PID_W'(i);
			end
		end
	end

	// lowest free frame
	logic ff_found;
	logic [FR_W-1:0] ff_idx;
	always_comb begin
		ff_found = 1'b0;
		ff_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (!fused_q[i]) begin
				ff_found = 1'b1;
				ff_idx = FR_W'(i);
			end
		end
	end

	logic pid_ok;
	logic in_bounds;
	assign pid_ok = ({1'b0, proc_id} < 4'(PROCS)) && run_q[PID_W'(proc_id)];
	assign in_bounds = {1'b0, vaddr} <
		(10'(pages_q[PID_W'(proc_id)]) << OFF_W);

	// outcome of the word at the input
	status_t acc_status;
	logic create_ok;
	logic [2:0] acc_state;
	always_comb begin
		acc_status = ST_OK;
		create_ok = 1'b0;
		acc_state = S_DONE;
		if (opcode == OP_CREATE) begin
			priority if (too_large) acc_status = ST_TOO_LARGE;
			else if (!free_found) acc_status = ST_NO_SLOT;
			else if ({1'b0, need} > 6'(FRAMES) - 6'(budget_q))
				acc_status = ST_NO_PAGES;
			else create_ok = 1'b1;
		end else if (!pid_ok) begin
			acc_status = ST_NOT_RUNNING;
		end else if (opcode == OP_EXIT) begin
			acc_state = S_EXIT;
		end else if (!in_bounds) begin
			acc_status = ST_BOUNDS;
		end else begin
			acc_state = S_MAP;
		end
	end

	pte_t walk_pte;
	assign walk_pte = pt_rd;

	always_comb begin
		pt_req = '0;
		pm_req = '0;
		unique case (state_q)
			S_CLR: begin
				pt_req.we = 1'b1;
				pt_req.addr = clr_q[PT_AW-1:0];
			end
			S_IDLE: begin
				pt_req.addr = {PID_W'(proc_id), vaddr[OFF_W +: VP_W]};
			end
			S_MAP: begin
				pt_req.addr = {pid_q, vp_q};
				if (!pt_rd.present && ff_found) begin
					pt_req.we = 1'b1;
					pt_req.wd = '{present: 1'b1, frame: ff_idx};
				end
			end
			S_MEM: begin
				pm_req.we = (op_q == OP_WRITE);
				pm_req.addr = {frame_q, off_q};
				pm_req.wd = wd_q;
			end
			S_EXIT: begin
				// clear entry walk_q while its old value is read out
				pt_req.we = !walk_q[VP_W];
				pt_req.addr = {pid_q, walk_q[VP_W-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			run_q <= '0;
			for (int i = 0; i < PROCS; i++) pages_q[i] <= '0;
			fused_q <= '0;
			budget_q <= '0;
			out_valid <= 1'b0;
			walk_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (state_q == S_DONE) out_valid <= 1'b1;
			else if (take) out_valid <= 1'b0;
			rd_pend_q <= (state_q == S_MEM) && (op_q == OP_READ);
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (PT_AW+1)'(PROCS*VIRT_PAGES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						op_q <= opcode_t'(opcode);
						pid_q <= PID_W'(proc_id);
						vp_q <= vaddr[OFF_W +: VP_W];
						off_q <= vaddr[OFF_W-1:0];
						wd_q <= wdata;
						status <= acc_status;
						new_pid <= create_ok ? free_pid : '0;
						rdata <= '0;
						walk_q <= '0;
						state_q <= acc_state;
						if (create_ok) begin
							budget_q <= budget_q + BUD_W'(need);
							pages_q[free_pid] <= need;
							run_q[free_pid] <= 1'b1;
							// fresh slot's entries were cleared on exit or reset
						end
					end
				end
				S_MAP: begin
					if (pt_rd.present) begin
						frame_q <= pt_rd.frame;
						state_q <= S_MEM;
					end else if (ff_found) begin
						fused_q[ff_idx] <= 1'b1;
						frame_q <= ff_idx;
						state_q <= S_MEM;
					end else begin
						status <= ST_NO_FRAME;
						state_q <= S_DONE;
					end
				end
				S_MEM: begin
					state_q <= S_DONE;
				end
				S_EXIT: begin
					// read entry walk_q, free entry walk_q-1 returned this cycle
					walk_q <= walk_q + 1'b1;
					if (walk_q != '0 && walk_pte.present) fused_q[walk_pte.frame] <= 1'b0;
					if (walk_q == (VP_W+1)'(VIRT_PAGES)) begin
						state_q <= S_DONE;
						if (budget_q >= BUD_W'(pages_q[pid_q]))
							budget_q <= budget_q - BUD_W'(pages_q[pid_q]);
						else budget_q <= '0;
						pages_q[pid_q] <= '0;
						run_q[pid_q] <= 1'b0;
					end
				end
				S_DONE: begin
					if (rd_pend_q) rdata <= pm_rd;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready) else $error("second word accepted early");
	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		budget_q <= BUD_W'(FRAMES)) else $error("page budget overflow");
endmodule
`default_nettype wire
